@@ hw/rtl/lookahead_waypoint_guidance_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Lookahead waypoint guidance: assertion macros
// Shared property wrappers, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOOKAHEAD_WAYPOINT_GUIDANCE_UNIT_DEFINES_SVH
`define LOOKAHEAD_WAYPOINT_GUIDANCE_UNIT_DEFINES_SVH

// same-cycle implication
`define LWG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LWG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lwg_pkg.sv @@
// ----------------------------------------------------------------------------
// lwg_pkg
// Types and constants shared by the lookahead waypoint guidance unit.
// ----------------------------------------------------------------------------
package lwg_pkg;

  localparam int MAX_WAYPOINTS = 64;
  localparam int SLOT_W        = 6;
  localparam int CNT_W         = 7;
  localparam int COORD_W       = 32;
  localparam int CFG_W         = 31;
  localparam int Q14_W         = 16;
  localparam logic [Q14_W-1:0] Q14_ONE = 16'd16384;

  typedef enum logic [1:0] {
    CFG_ACCEPT_RADIUS = 2'd0,
    CFG_LOOKAHEAD     = 2'd1,
    CFG_HOLD_FINAL    = 2'd2,
    CFG_WP_COUNT      = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_req_t;

  typedef struct packed {
    logic                      mode;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [SLOT_W-1:0]         entry_slot;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [Q14_W-1:0]   heading_w;
    logic signed [Q14_W-1:0]   heading_z;
    logic [SLOT_W-1:0]         active_slot;
  } out_item_t;

endpackage

@@ hw/rtl/lookahead_waypoint_guidance_unit.sv @@
// ----------------------------------------------------------------------------
// lookahead_waypoint_guidance_unit
// Carrot-chasing guidance: waypoint table, distance check, lookahead setpoint
// and half-angle yaw quaternion, all on one shared iterative unit.
// ----------------------------------------------------------------------------
// Usage:
//  - in_data is taken when start is high and busy is low. mode 0 writes a
//    waypoint into the table in that cycle (no result, busy stays low).
//  - mode 1 is a tick with the vehicle position; busy rises until done.
//  - Tick timing is set by the shared divide/root unit. Full tick: 4 roots
//    + 4 divides plus control; the result strobes in the cycle after busy
//    ends. Zero distance skips the setpoint divides; a zero heading vector
//    skips the quaternion; a dropped result at the last waypoint ends the
//    tick after the distance root.
//  - Each result sits on out_data for one cycle with out_valid high; the
//    receiver cannot stall, so nothing is held back. A new transaction may
//    start in the cycle out_valid is high.
//  - cfg_we/cfg_index/cfg_wdata write a register at once; write only while
//    idle.
//  - Reset: active slot 0, registers at defaults; table contents undefined.
// ----------------------------------------------------------------------------
`include "lookahead_waypoint_guidance_unit_defines.svh"

module lookahead_waypoint_guidance_unit import lwg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  typedef enum logic [18:0] {
    ST_IDLE      = 19'h00001,
    ST_RD        = 19'h00002,
    ST_VEC       = 19'h00004,
    ST_SQ_A      = 19'h00008,
    ST_SQ_B      = 19'h00010,
    ST_ROOT_GO   = 19'h00020,
    ST_ROOT_WAIT = 19'h00040,
    ST_DECIDE    = 19'h00080,
    ST_RD2       = 19'h00100,
    ST_SPLOAD    = 19'h00200,
    ST_MUL       = 19'h00400,
    ST_DIV_GO    = 19'h00800,
    ST_DIV_WAIT  = 19'h01000,
    ST_HCHK      = 19'h02000,
    ST_HDIV_GO   = 19'h04000,
    ST_HDIV_WAIT = 19'h08000,
    ST_HSQ_GO    = 19'h10000,
    ST_HSQ_WAIT  = 19'h20000,
    ST_EMIT      = 19'h40000
  } state_t;

  // control
  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              axis_r, axis_nxt;   // 0: x / w, 1: y / z
  logic              hd_r, hd_nxt;       // 0: distance pass, 1: heading pass
  logic              out_valid_r;
  logic [CFG_W-1:0]  radius_r, look_r;
  logic              hold_r;
  logic [CNT_W-1:0]  count_r;

  // payload
  logic [2*COORD_W-1:0]      tbl_r [MAX_WAYPOINTS];
  logic [2*COORD_W-1:0]      mem_q_r;
  logic signed [COORD_W-1:0] cx_r, cy_r, spx_r, spy_r;
  logic [30:0]               ma_r, mb_r, step_r;
  logic                      s_r, sgx_r, sgy_r;
  logic [31:0]               r_r;
  logic [61:0]               prod_r;
  logic [62:0]               acc_r;
  logic [Q14_W-1:0]          w_r, z_r;
  out_item_t                 out_r;

  // shared unit
  iter_req_t   ireq;
  logic [63:0] inum;
  logic        idone;
  logic [31:0] ires;
  logic [33:0] irem;

  lwg_iter_unit u_iter (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ireq),
    .num  (inum),
    .den  (r_r),
    .done (idone),
    .res  (ires),
    .rem  (irem)
  );

  // effective waypoint count: 0 acts as 1, above the table depth saturates
  logic [CNT_W-1:0] n_eff;
  always_comb begin
    if (count_r == '0)
      n_eff = CNT_W'(1);
    else if (count_r > CNT_W'(MAX_WAYPOINTS))
      n_eff = CNT_W'(MAX_WAYPOINTS);
    else
      n_eff = count_r;
  end

  logic tick_acc, load_acc;
  assign tick_acc = start && !busy && in_data.mode;
  assign load_acc = start && !busy && !in_data.mode;

  // vector reduction: delta, magnitude, common right shift of at most one
  logic [COORD_W-1:0] vx_op, vy_op;
  logic [32:0]        ex, ey, mx, my;
  logic               vs;
  assign vx_op = hd_r ? spx_r : mem_q_r[2*COORD_W-1:COORD_W];
  assign vy_op = hd_r ? spy_r : mem_q_r[COORD_W-1:0];
  assign ex = {vx_op[31], vx_op} - {cx_r[31], cx_r};
  assign ey = {vy_op[31], vy_op} - {cy_r[31], cy_r};
  assign mx = ex[32] ? (33'd0 - ex) : ex;
  assign my = ey[32] ? (33'd0 - ey) : ey;
  assign vs = mx[31] | my[31];

  // multiplier: one product per cycle, registered
  logic [30:0] mul_a, mul_b;
  always_comb begin
    case (state_r)
      ST_SQ_A: begin
        mul_a = ma_r;
        mul_b = ma_r;
      end
      ST_SQ_B: begin
        mul_a = mb_r;
        mul_b = mb_r;
      end
      default: begin
        mul_a = axis_r ? mb_r : ma_r;
        mul_b = step_r;
      end
    endcase
  end

  // distance and step
  logic [32:0] dist_len;
  logic        near;
  logic [30:0] step_v;
  assign dist_len = s_r ? {r_r, 1'b0} : {1'b0, r_r};
  assign near     = dist_len < {2'b00, radius_r};
  assign step_v   = ({2'b00, look_r} < dist_len) ? look_r : dist_len[30:0];

  // setpoint offset and saturation
  logic [33:0] off34, c34, sum34;
  logic        neg_sel;
  logic [31:0] sat_v;
  assign off34   = {2'b00, ires};
  assign neg_sel = axis_r ? sgy_r : sgx_r;
  assign c34     = axis_r ? {{2{cy_r[31]}}, cy_r} : {{2{cx_r[31]}}, cx_r};
  assign sum34   = neg_sel ? (c34 - off34) : (c34 + off34);
  always_comb begin
    if (sum34[33] == sum34[31] && sum34[32] == sum34[31])
      sat_v = sum34[31:0];
    else if (sum34[33])
      sat_v = 32'h8000_0000;
    else
      sat_v = 32'h7FFF_FFFF;
  end

  // heading: r +/- |hx| term
  logic [32:0] hsum, hdif, hsel;
  assign hsum = {1'b0, r_r} + {2'b00, ma_r};
  assign hdif = {1'b0, r_r} - {2'b00, ma_r};
  always_comb begin
    if (axis_r)
      hsel = sgx_r ? hsum : hdif;
    else
      hsel = sgx_r ? hdif : hsum;
  end

  // rounded root
  logic [Q14_W-1:0] root_rnd;
  assign root_rnd = ires[15:0] + Q14_W'(irem > {18'd0, ires[15:0]});

  // shared unit requests
  always_comb begin
    ireq.start = 1'b0;
    ireq.op    = OP_DIV;
    inum       = {1'b0, acc_r} + {2'b00, prod_r};
    case (state_r)
      ST_ROOT_GO: begin
        ireq.start = 1'b1;
        ireq.op    = OP_SQRT;
      end
      ST_DIV_GO: begin
        ireq.start = 1'b1;
        inum       = {2'b00, prod_r} + {33'd0, r_r[31:1]};
      end
      ST_HDIV_GO: begin
        ireq.start = 1'b1;
        inum       = {4'd0, hsel, 27'd0} + {33'd0, r_r[31:1]};
      end
      ST_HSQ_GO: begin
        ireq.start = 1'b1;
        ireq.op    = OP_SQRT;
        inum       = {32'd0, ires};
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    axis_nxt  = axis_r;
    hd_nxt    = hd_r;
    case (state_r)
      ST_IDLE: begin
        if (tick_acc) begin
          hd_nxt    = 1'b0;
          state_nxt = ST_RD;
          if ({1'b0, slot_r} >= n_eff)
            slot_nxt = SLOT_W'(n_eff - CNT_W'(1));
        end
      end
      ST_RD:      state_nxt = ST_VEC;
      ST_VEC:     state_nxt = ST_SQ_A;
      ST_SQ_A:    state_nxt = ST_SQ_B;
      ST_SQ_B:    state_nxt = ST_ROOT_GO;
      ST_ROOT_GO: state_nxt = ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        if (idone)
          state_nxt = hd_r ? ST_HCHK : ST_DECIDE;
      end
      ST_DECIDE: begin
        axis_nxt = 1'b0;
        if (near && ({1'b0, slot_r} + CNT_W'(1) < n_eff))
          slot_nxt = slot_r + SLOT_W'(1);
        if (near && !({1'b0, slot_r} + CNT_W'(1) < n_eff) && !hold_r)
          state_nxt = ST_IDLE;          // last waypoint reached, no result
        else if (r_r == '0)
          state_nxt = ST_RD2;
        else
          state_nxt = ST_MUL;
      end
      ST_RD2: state_nxt = ST_SPLOAD;
      ST_SPLOAD: begin
        hd_nxt    = 1'b1;
        state_nxt = ST_VEC;
      end
      ST_MUL:    state_nxt = ST_DIV_GO;
      ST_DIV_GO: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (idone) begin
          if (axis_r) begin
            hd_nxt    = 1'b1;
            state_nxt = ST_VEC;
          end else begin
            axis_nxt  = 1'b1;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_HCHK: begin
        axis_nxt  = 1'b0;
        state_nxt = (r_r == '0) ? ST_EMIT : ST_HDIV_GO;
      end
      ST_HDIV_GO: state_nxt = ST_HDIV_WAIT;
      ST_HDIV_WAIT: begin
        if (idone)
          state_nxt = ST_HSQ_GO;
      end
      ST_HSQ_GO: state_nxt = ST_HSQ_WAIT;
      ST_HSQ_WAIT: begin
        if (idone) begin
          if (axis_r) begin
            state_nxt = ST_EMIT;
          end else begin
            axis_nxt  = 1'b1;
            state_nxt = ST_HDIV_GO;
          end
        end
      end
      ST_EMIT:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      axis_r      <= 1'b0;
      hd_r        <= 1'b0;
      out_valid_r <= 1'b0;
      radius_r    <= CFG_W'(32768);
      look_r      <= CFG_W'(98304);
      hold_r      <= 1'b1;
      count_r     <= CNT_W'(1);
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      axis_r      <= axis_nxt;
      hd_r        <= hd_nxt;
      out_valid_r <= (state_r == ST_EMIT);
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACCEPT_RADIUS: radius_r <= cfg_wdata;
          CFG_LOOKAHEAD:     look_r   <= cfg_wdata;
          CFG_HOLD_FINAL:    hold_r   <= cfg_wdata[0];
          CFG_WP_COUNT:      count_r  <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // waypoint table: one write port, one registered read at the active slot
  always_ff @(posedge clk) begin
    if (load_acc)
      tbl_r[in_data.entry_slot] <= {in_data.coord_x, in_data.coord_y};
    mem_q_r <= tbl_r[slot_r];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      cx_r <= in_data.coord_x;
      cy_r <= in_data.coord_y;
    end
    case (state_r)
      ST_VEC: begin
        s_r   <= vs;
        sgx_r <= ex[32];
        sgy_r <= ey[32];
        ma_r  <= vs ? mx[31:1] : mx[30:0];
        mb_r  <= vs ? my[31:1] : my[30:0];
      end
      ST_SQ_A: prod_r <= mul_a * mul_b;
      ST_SQ_B: begin
        acc_r  <= {1'b0, prod_r};
        prod_r <= mul_a * mul_b;
      end
      ST_ROOT_WAIT: begin
        if (idone)
          r_r <= ires;
      end
      ST_DECIDE: step_r <= step_v;
      ST_SPLOAD: begin
        spx_r <= mem_q_r[2*COORD_W-1:COORD_W];
        spy_r <= mem_q_r[COORD_W-1:0];
      end
      ST_MUL: prod_r <= mul_a * mul_b;
      ST_DIV_WAIT: begin
        if (idone) begin
          if (axis_r)
            spy_r <= sat_v;
          else
            spx_r <= sat_v;
        end
      end
      ST_HCHK: begin
        w_r <= Q14_ONE;
        z_r <= '0;
      end
      ST_HSQ_WAIT: begin
        if (idone) begin
          if (axis_r)
            z_r <= sgy_r ? (Q14_W'(0) - root_rnd) : root_rnd;
          else
            w_r <= root_rnd;
        end
      end
      ST_EMIT: begin
        out_r.target_x    <= spx_r;
        out_r.target_y    <= spy_r;
        out_r.heading_w   <= w_r;
        out_r.heading_z   <= z_r;
        out_r.active_slot <= slot_r;
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // emit step is always followed by the result strobe
  `LWG_ASSERT_NEXT(a_emit_strobe, state_r == ST_EMIT, out_valid_r, "emit did not strobe")
  // active slot is inside the table once the distance pass starts
  `LWG_ASSERT_IMPL(a_slot_range, (state_r == ST_VEC) && !hd_r, ({1'b0, slot_r} < n_eff), "slot past count")
  // shared unit finishes only while the sequencer waits on it
  `LWG_ASSERT_IMPL(a_iter_done, idone, (state_r == ST_ROOT_WAIT) || (state_r == ST_DIV_WAIT) || (state_r == ST_HDIV_WAIT) || (state_r == ST_HSQ_WAIT), "unexpected unit done")

endmodule

@@ hw/rtl/lwg_iter_unit.sv @@
// ----------------------------------------------------------------------------
// lwg_iter_unit
// Shared shift-subtract unit: restoring divide (64 steps) or integer root
// (32 steps), one step per cycle, remainder kept for rounding.
// ----------------------------------------------------------------------------
module lwg_iter_unit import lwg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  iter_req_t   req,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] res,
  output logic [33:0] rem
);

  logic        busy_r;
  logic        done_r;
  iter_op_t    op_r;
  logic [5:0]  cnt_r;
  logic [63:0] n_r;
  logic [31:0] d_r;
  logic [31:0] q_r;
  logic [33:0] rem_r;

  logic [35:0] t_val;
  logic [35:0] trial;
  logic [36:0] diff;
  logic        ge;
  logic [5:0]  last;

  always_comb begin
    if (op_r == OP_SQRT) begin
      t_val = {rem_r, n_r[63:62]};
      trial = {2'b00, q_r, 2'b01};
      last  = 6'd31;
    end else begin
      t_val = {1'b0, rem_r, n_r[63]};
      trial = {4'b0000, d_r};
      last  = 6'd63;
    end
    diff = {1'b0, t_val} - {1'b0, trial};
    ge   = ~diff[36];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      n_r   <= num;
      d_r   <= den;
      q_r   <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[33:0] : t_val[33:0];
      q_r   <= {q_r[30:0], ge};
      n_r   <= (op_r == OP_SQRT) ? {n_r[61:0], 2'b00} : {n_r[62:0], 1'b0};
    end
  end

  assign done = done_r;
  assign res  = q_r;
  assign rem  = rem_r;

endmodule
